// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: hw/rtl/sdvs_pkg.sv
// ----------------------------------------------------------------------------
// sdvs_pkg
// Types, constants and tables of the snare drum voice.
// ----------------------------------------------------------------------------
package sdvs_pkg;

	localparam int BLOCK_LOG2  = 5;
	localparam int BLOCK_LEN   = 1 << BLOCK_LOG2;
	localparam int CNT_W       = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;
	localparam int SINE_POINTS = 256;
	localparam int IN_W        = 184;

	localparam logic signed [31:0] Q31_ONE         = 32'sh7fffffff;
	localparam logic signed [31:0] PARAM_NORM      = 32'sd66052;
	localparam logic signed [31:0] INC_A440        = 32'sd39370534;
	localparam logic signed [31:0] EXP_SCALE       = 32'sh0aaaaaab;
	localparam logic signed [31:0] POLY_C3         = 32'sh09e79bdb;
	localparam logic signed [31:0] POLY_C2         = 32'sh1d0c5fa9;
	localparam logic signed [31:0] POLY_C1         = 32'sh5903d9d4;
	localparam logic signed [31:0] HALF_ONE        = 32'sh40000000;
	localparam logic signed [31:0] MODE_RATIO_FRAC = 32'sh4f5c28f6;
	localparam logic signed [31:0] MODE_TWO_LEVEL  = 32'sh46666666;
	localparam logic signed [31:0] HIGHPASS_COEF   = 32'sh7834793e;
	localparam logic signed [31:0] NOISE_LEVEL     = 32'sh60000000;
	localparam logic signed [31:0] GAIN_DIP        = 32'sh39999999;
	localparam logic [31:0]        LCG_MUL         = 32'd1664525;
	localparam logic [31:0]        LCG_ADD         = 32'd1013904223;
	localparam logic [31:0]        SEED_INIT       = 32'h2545f491;
	localparam logic signed [31:0] NOTE_MAX        = 32'sd8323072;
	localparam logic signed [31:0] NOTE_BIAS       = 32'sd4849664;
	localparam logic [14:0]        WORD_MAX        = 15'h7f00;

	typedef enum logic [5:0] {
		OP_NOP, OP_LOAD, OP_DB, OP_DS,
		OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6,
		OP_D0, OP_D1, OP_D2, OP_D3, OP_D4, OP_D5,
		OP_C0, OP_C1, OP_C2, OP_C3, OP_L0, OP_RAMP,
		OP_S1, OP_S2, OP_S3, OP_S4, OP_S5, OP_S6,
		OP_S7, OP_S8, OP_S9, OP_S10, OP_S11, OP_S12
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_DB, ST_DS,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
		ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5,
		ST_C0, ST_C1, ST_C2, ST_C3, ST_L0, ST_RAMP,
		ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6,
		ST_S7, ST_S8, ST_S9, ST_S10, ST_S11, ST_S12
	} state_t;

	typedef struct packed {
		op_t  op;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef logic [31:0] sine_tab_t [SINE_POINTS];

	localparam logic [31:0] BRIGHT_ROM [17] = '{
		32'h129b499f, 32'h157332b1, 32'h18ad3dd8, 32'h1c522d1b, 32'h2069f7b5,
		32'h24fb1c69, 32'h2a09c596, 32'h2f96bf14, 32'h359e44d6, 32'h3c16bc04,
		32'h42ef772f, 32'h4a0fb888, 32'h51563894, 32'h58998735, 32'h5fa99fd7,
		32'h6652f47d, 32'h6c62fabb
	};

	function automatic logic [63:0] wide_mul_shr(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		pr = pr >> sh;
		return pr[63:0];
	endfunction

	function automatic logic [63:0] series_div(logic [63:0] v, int k);
		logic [63:0] r;
		case (k)
			1:       r = v / 6;
			2:       r = v / 20;
			3:       r = v / 42;
			4:       r = v / 72;
			5:       r = v / 110;
			6:       r = v / 156;
			7:       r = v / 210;
			8:       r = v / 272;
			9:       r = v / 342;
			10:      r = v / 420;
			11:      r = v / 506;
			default: r = v / 600;
		endcase
		return r;
	endfunction

	// Taylor series of sin over the first quadrant, rounded to Q31
	function automatic logic [31:0] quarter_sine(int i);
		logic [63:0] x, x2, term, sum, v;
		x    = (64'h6487ED5110B4611A >> 7) * 64'(i);
		x2   = wide_mul_shr(x, x, 61);
		term = x;
		sum  = x;
		for (int k = 1; k <= 12; k++) begin
			term = series_div(wide_mul_shr(term, x2, 61), k);
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		v = (wide_mul_shr(sum, 64'h7fffffff, 60) + 64'd1) >> 1;
		if (v > 64'h7fffffff)
			v = 64'h7fffffff;
		return v[31:0];
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t t;
		logic [31:0] q;
		for (int i = 0; i <= SINE_POINTS / 4; i++) begin
			q = quarter_sine(i);
			t[i] = q;
			t[SINE_POINTS / 2 - i] = q;
			t[SINE_POINTS / 2 + i] = 32'd0 - q;
			if (i > 0)
				t[SINE_POINTS - i] = 32'd0 - q;
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_ROM = build_sine();

endpackage

// File: hw/rtl/sdvs_ctrl.sv
// ----------------------------------------------------------------------------
// sdvs_ctrl
// Sequencer: one datapath op per cycle for setup and samples unless stalled.
// ----------------------------------------------------------------------------
module sdvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sdvs_pkg::status_t status,
	output sdvs_pkg::cmd_t    cmd
);

	sdvs_pkg::state_t state_q, state_d;
	logic [sdvs_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic last;

	assign last = (cnt_q == sdvs_pkg::CNT_W'(sdvs_pkg::BLOCK_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdvs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.op   = sdvs_pkg::OP_NOP;
		cmd.last = last;
		unique case (state_q)
			sdvs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = sdvs_pkg::OP_LOAD;
					cnt_d   = '0;
					state_d = sdvs_pkg::ST_DB;
				end
			end
			sdvs_pkg::ST_DB:   begin cmd.op = sdvs_pkg::OP_DB;   state_d = sdvs_pkg::ST_DS;   end
			sdvs_pkg::ST_DS:   begin cmd.op = sdvs_pkg::OP_DS;   state_d = sdvs_pkg::ST_P1;   end
			sdvs_pkg::ST_P1:   begin cmd.op = sdvs_pkg::OP_P1;   state_d = sdvs_pkg::ST_P2;   end
			sdvs_pkg::ST_P2:   begin cmd.op = sdvs_pkg::OP_P2;   state_d = sdvs_pkg::ST_P3;   end
			sdvs_pkg::ST_P3:   begin cmd.op = sdvs_pkg::OP_P3;   state_d = sdvs_pkg::ST_P4;   end
			sdvs_pkg::ST_P4:   begin cmd.op = sdvs_pkg::OP_P4;   state_d = sdvs_pkg::ST_P5;   end
			sdvs_pkg::ST_P5:   begin cmd.op = sdvs_pkg::OP_P5;   state_d = sdvs_pkg::ST_P6;   end
			sdvs_pkg::ST_P6:   begin cmd.op = sdvs_pkg::OP_P6;   state_d = sdvs_pkg::ST_D0;   end
			sdvs_pkg::ST_D0:   begin cmd.op = sdvs_pkg::OP_D0;   state_d = sdvs_pkg::ST_D1;   end
			sdvs_pkg::ST_D1:   begin cmd.op = sdvs_pkg::OP_D1;   state_d = sdvs_pkg::ST_D2;   end
			sdvs_pkg::ST_D2:   begin cmd.op = sdvs_pkg::OP_D2;   state_d = sdvs_pkg::ST_D3;   end
			sdvs_pkg::ST_D3:   begin cmd.op = sdvs_pkg::OP_D3;   state_d = sdvs_pkg::ST_D4;   end
			sdvs_pkg::ST_D4:   begin cmd.op = sdvs_pkg::OP_D4;   state_d = sdvs_pkg::ST_D5;   end
			sdvs_pkg::ST_D5:   begin cmd.op = sdvs_pkg::OP_D5;   state_d = sdvs_pkg::ST_C0;   end
			sdvs_pkg::ST_C0:   begin cmd.op = sdvs_pkg::OP_C0;   state_d = sdvs_pkg::ST_C1;   end
			sdvs_pkg::ST_C1:   begin cmd.op = sdvs_pkg::OP_C1;   state_d = sdvs_pkg::ST_C2;   end
			sdvs_pkg::ST_C2:   begin cmd.op = sdvs_pkg::OP_C2;   state_d = sdvs_pkg::ST_C3;   end
			sdvs_pkg::ST_C3:   begin cmd.op = sdvs_pkg::OP_C3;   state_d = sdvs_pkg::ST_L0;   end
			sdvs_pkg::ST_L0:   begin cmd.op = sdvs_pkg::OP_L0;   state_d = sdvs_pkg::ST_RAMP; end
			sdvs_pkg::ST_RAMP: begin cmd.op = sdvs_pkg::OP_RAMP; state_d = sdvs_pkg::ST_S1;   end
			sdvs_pkg::ST_S1:   begin cmd.op = sdvs_pkg::OP_S1;   state_d = sdvs_pkg::ST_S2;   end
			sdvs_pkg::ST_S2:   begin cmd.op = sdvs_pkg::OP_S2;   state_d = sdvs_pkg::ST_S3;   end
			sdvs_pkg::ST_S3:   begin cmd.op = sdvs_pkg::OP_S3;   state_d = sdvs_pkg::ST_S4;   end
			sdvs_pkg::ST_S4:   begin cmd.op = sdvs_pkg::OP_S4;   state_d = sdvs_pkg::ST_S5;   end
			sdvs_pkg::ST_S5:   begin cmd.op = sdvs_pkg::OP_S5;   state_d = sdvs_pkg::ST_S6;   end
			sdvs_pkg::ST_S6:   begin cmd.op = sdvs_pkg::OP_S6;   state_d = sdvs_pkg::ST_S7;   end
			sdvs_pkg::ST_S7:   begin cmd.op = sdvs_pkg::OP_S7;   state_d = sdvs_pkg::ST_S8;   end
			sdvs_pkg::ST_S8:   begin cmd.op = sdvs_pkg::OP_S8;   state_d = sdvs_pkg::ST_S9;   end
			sdvs_pkg::ST_S9:   begin cmd.op = sdvs_pkg::OP_S9;   state_d = sdvs_pkg::ST_S10;  end
			sdvs_pkg::ST_S10:  begin cmd.op = sdvs_pkg::OP_S10;  state_d = sdvs_pkg::ST_S11;  end
			sdvs_pkg::ST_S11:  begin cmd.op = sdvs_pkg::OP_S11;  state_d = sdvs_pkg::ST_S12;  end
			sdvs_pkg::ST_S12: begin
				// hold until the output register can take the beat
				if (status.out_free) begin
					cmd.op = sdvs_pkg::OP_S12;
					if (last) begin
						state_d = sdvs_pkg::ST_IDLE;
					end else begin
						cnt_d   = cnt_q + 1'b1;
						state_d = sdvs_pkg::ST_S1;
					end
				end
			end
			default: state_d = sdvs_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: hw/rtl/sdvs_datapath.sv
// ----------------------------------------------------------------------------
// sdvs_datapath
// Voice state, one shared Q31 multiplier and the output register.
// ----------------------------------------------------------------------------
module sdvs_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdvs_pkg::cmd_t            cmd,
	input  logic                      in_kind,
	input  logic [sdvs_pkg::IN_W-1:0] in_data,
	input  logic                      out_ready,
	output sdvs_pkg::status_t         status,
	output logic [31:0]               out_data,
	output logic                      out_last,
	output logic                      out_valid
);

	function automatic logic [14:0] clamp_word(logic signed [15:0] w);
		logic [14:0] r;
		if (w < 0)
			r = '0;
		else if (w[14:0] > sdvs_pkg::WORD_MAX)
			r = sdvs_pkg::WORD_MAX;
		else
			r = w[14:0];
		return r;
	endfunction

	logic               trig_q;
	logic [14:0]        sweep_q, color_q, shape_q;
	logic signed [31:0] fb_q, fs_q, n_q;
	logic signed [31:0] phase1_q, phase2_q, inc_now_q, inc_goal_q;
	logic signed [31:0] benv_now_q, benv_goal_q, senv_q;
	logic [31:0]        seed_q;
	logic signed [31:0] hpy_q, hpx_q, lp1_q, lp2_q;
	logic signed [31:0] ta_q, to_q, ty_q, inc0_q, gn_q, gb_q, glp_q;
	logic signed [31:0] dinc_q, deb_q, incw_q, ebw_q;
	logic signed [31:0] s1_q, s2_q, e2_q, body_q;
	logic [31:0]        out_data_q;
	logic               out_last_q, out_valid_q;

	logic signed [31:0] mul_a, mul_b, fm;
	logic signed [63:0] prod;
	logic signed [31:0] px, noise_x;
	logic signed [31:0] ph_sel, sin_t0, sin_t1, br_b0, br_b1;
	logic signed [15:0] e_exp;
	logic [15:0]        e_neg;
	logic signed [31:0] shifted;
	logic signed [63:0] cmp_rhs;
	logic signed [31:0] goal;
	logic signed [31:0] n_raw, n_cl;
	logic [3:0]         br_idx;

	assign px      = {1'b0, to_q[15:0], 15'd0};
	assign noise_x = $signed(seed_q) >>> 2;
	assign ph_sel  = (cmd.op == sdvs_pkg::OP_S3) ? phase2_q : phase1_q;
	assign sin_t0  = sdvs_pkg::SINE_ROM[ph_sel[31:24]];
	assign sin_t1  = sdvs_pkg::SINE_ROM[ph_sel[31:24] + 8'd1];
	assign br_idx  = shape_q[14:11];
	assign br_b0   = sdvs_pkg::BRIGHT_ROM[br_idx];
	assign br_b1   = sdvs_pkg::BRIGHT_ROM[{1'b0, br_idx} + 5'd1];

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			sdvs_pkg::OP_DB:  begin mul_a = benv_goal_q; mul_b = 32'sd0 - fb_q; end
			sdvs_pkg::OP_DS:  begin mul_a = senv_q; mul_b = 32'sd0 - fs_q; end
			sdvs_pkg::OP_P1:  begin mul_a = n_q; mul_b = sdvs_pkg::EXP_SCALE; end
			sdvs_pkg::OP_P2:  begin mul_a = sdvs_pkg::POLY_C3; mul_b = px; end
			sdvs_pkg::OP_P3,
			sdvs_pkg::OP_P4:  begin mul_a = ty_q; mul_b = px; end
			sdvs_pkg::OP_P5:  begin
				mul_a = sdvs_pkg::HALF_ONE + (ty_q >>> 1);
				mul_b = sdvs_pkg::INC_A440;
			end
			sdvs_pkg::OP_D0:  begin mul_a = {17'd0, sweep_q}; mul_b = sdvs_pkg::PARAM_NORM; end
			sdvs_pkg::OP_D1:  begin mul_a = ta_q; mul_b = ta_q; end
			sdvs_pkg::OP_D2:  begin mul_a = ta_q; mul_b = sdvs_pkg::MODE_TWO_LEVEL; end
			sdvs_pkg::OP_D3:  begin mul_a = ta_q; mul_b = senv_q; end
			sdvs_pkg::OP_D4:  begin mul_a = inc0_q; mul_b = ta_q; end
			sdvs_pkg::OP_C0:  begin mul_a = {17'd0, color_q}; mul_b = sdvs_pkg::PARAM_NORM; end
			sdvs_pkg::OP_C1:  begin mul_a = ta_q; mul_b = sdvs_pkg::NOISE_LEVEL; end
			sdvs_pkg::OP_C2:  begin mul_a = ta_q; mul_b = ta_q; end
			sdvs_pkg::OP_C3:  begin mul_a = ty_q; mul_b = sdvs_pkg::GAIN_DIP; end
			sdvs_pkg::OP_L0:  begin mul_a = br_b1 - br_b0; mul_b = {1'b0, shape_q[10:0], 20'd0}; end
			sdvs_pkg::OP_S1:  begin mul_a = incw_q; mul_b = sdvs_pkg::MODE_RATIO_FRAC; end
			sdvs_pkg::OP_S2,
			sdvs_pkg::OP_S3:  begin mul_a = sin_t1 - sin_t0; mul_b = {1'b0, ph_sel[23:0], 7'd0}; end
			sdvs_pkg::OP_S4:  begin mul_a = ebw_q; mul_b = sdvs_pkg::MODE_TWO_LEVEL; end
			sdvs_pkg::OP_S5:  begin mul_a = s2_q; mul_b = e2_q; end
			sdvs_pkg::OP_S6:  begin mul_a = body_q; mul_b = ebw_q; end
			sdvs_pkg::OP_S7:  begin mul_a = body_q; mul_b = gb_q; end
			sdvs_pkg::OP_S8:  begin mul_a = $signed(seed_q); mul_b = $signed(sdvs_pkg::LCG_MUL); end
			sdvs_pkg::OP_S9:  begin
				mul_a = sdvs_pkg::HIGHPASS_COEF;
				mul_b = hpy_q + noise_x - hpx_q;
			end
			sdvs_pkg::OP_S10: begin mul_a = glp_q; mul_b = hpy_q - lp1_q; end
			sdvs_pkg::OP_S11: begin mul_a = glp_q; mul_b = lp1_q - lp2_q; end
			sdvs_pkg::OP_S12: begin mul_a = lp2_q; mul_b = gn_q; end
			default: ;
		endcase
	end

	// floor Q31 product, only -1 x -1 overflows
	assign prod = mul_a * mul_b;
	assign fm   = (prod[62] && !prod[63]) ? sdvs_pkg::Q31_ONE : prod[62:31];

	always_comb begin
		e_exp = to_q[31:16];
		e_neg = 16'd0 - e_exp;
		if (e_exp >= 16'sd32)
			shifted = '0;
		else if (e_exp >= 16'sd0)
			shifted = ta_q <<< e_exp[4:0];
		else if (e_exp <= -16'sd32)
			shifted = ta_q >>> 31;
		else
			shifted = ta_q >>> e_neg[4:0];
	end

	always_comb begin
		cmp_rhs = (64'sh7fffffff - 64'(inc0_q)) >>> 2;
		if (64'(ta_q) > cmp_rhs)
			goal = sdvs_pkg::Q31_ONE;
		else
			goal = inc0_q + (ta_q <<< 2);
	end

	always_comb begin
		n_raw = (32'($signed(in_data[15:0])) <<< 8)
			+ ((32'($signed(in_data[31:16])) - 32'sd16384) <<< 3)
			- 32'sd4194304 + 32'($signed(in_data[55:32]));
		if (n_raw < 0)
			n_cl = '0;
		else if (n_raw > sdvs_pkg::NOTE_MAX)
			n_cl = sdvs_pkg::NOTE_MAX;
		else
			n_cl = n_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase1_q    <= '0;
			phase2_q    <= '0;
			inc_now_q   <= '0;
			inc_goal_q  <= '0;
			benv_now_q  <= '0;
			benv_goal_q <= '0;
			senv_q      <= '0;
			seed_q      <= '0;
			hpy_q       <= '0;
			hpx_q       <= '0;
			lp1_q       <= '0;
			lp2_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == sdvs_pkg::OP_S12)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				sdvs_pkg::OP_LOAD: begin
					if (in_kind) begin
						phase1_q    <= '0;
						phase2_q    <= sdvs_pkg::HALF_ONE;
						benv_now_q  <= sdvs_pkg::Q31_ONE;
						benv_goal_q <= sdvs_pkg::Q31_ONE;
						senv_q      <= sdvs_pkg::Q31_ONE;
						hpy_q       <= '0;
						hpx_q       <= '0;
						lp1_q       <= '0;
						lp2_q       <= '0;
						if (seed_q == 32'd0)
							seed_q <= sdvs_pkg::SEED_INIT;
					end
				end
				sdvs_pkg::OP_DB: if (!trig_q) benv_goal_q <= fm;
				sdvs_pkg::OP_DS: if (!trig_q) senv_q <= fm;
				sdvs_pkg::OP_D5: begin
					inc_goal_q <= goal;
					if (trig_q)
						inc_now_q <= goal;
				end
				sdvs_pkg::OP_S1: begin
					phase1_q <= phase1_q + incw_q;
					phase2_q <= phase2_q + incw_q + fm;
				end
				sdvs_pkg::OP_S8: seed_q <= prod[31:0] + sdvs_pkg::LCG_ADD;
				sdvs_pkg::OP_S9: begin
					hpy_q <= fm;
					hpx_q <= noise_x;
				end
				sdvs_pkg::OP_S10: lp1_q <= lp1_q + fm;
				sdvs_pkg::OP_S11: lp2_q <= lp2_q + fm;
				sdvs_pkg::OP_S12: begin
					if (cmd.last) begin
						inc_now_q  <= inc_goal_q;
						benv_now_q <= benv_goal_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (cmd.op)
			sdvs_pkg::OP_LOAD: begin
				trig_q  <= in_kind;
				sweep_q <= clamp_word(in_data[71:56]);
				color_q <= clamp_word(in_data[103:88]);
				shape_q <= clamp_word(in_data[119:104]);
				fb_q    <= in_data[151:120];
				fs_q    <= in_data[183:152];
				n_q     <= n_cl - sdvs_pkg::NOTE_BIAS;
			end
			sdvs_pkg::OP_P1:  to_q <= fm;
			sdvs_pkg::OP_P2:  ty_q <= fm + sdvs_pkg::POLY_C2;
			sdvs_pkg::OP_P3:  ty_q <= fm + sdvs_pkg::POLY_C1;
			sdvs_pkg::OP_P4:  ty_q <= fm;
			sdvs_pkg::OP_P5:  ta_q <= fm <<< 1;
			sdvs_pkg::OP_P6:  inc0_q <= shifted;
			sdvs_pkg::OP_D0:  ta_q <= prod[31:0];
			sdvs_pkg::OP_D1,
			sdvs_pkg::OP_D2,
			sdvs_pkg::OP_D3,
			sdvs_pkg::OP_D4:  ta_q <= fm;
			sdvs_pkg::OP_C0:  ta_q <= prod[31:0];
			sdvs_pkg::OP_C1:  gn_q <= fm;
			sdvs_pkg::OP_C2:  ty_q <= fm;
			sdvs_pkg::OP_C3:  gb_q <= sdvs_pkg::Q31_ONE - fm;
			sdvs_pkg::OP_L0:  glp_q <= br_b0 + fm;
			sdvs_pkg::OP_RAMP: begin
				dinc_q <= (inc_goal_q - inc_now_q) >>> sdvs_pkg::BLOCK_LOG2;
				deb_q  <= (benv_goal_q - benv_now_q) >>> sdvs_pkg::BLOCK_LOG2;
				incw_q <= inc_now_q;
				ebw_q  <= benv_now_q;
			end
			sdvs_pkg::OP_S2:  s1_q <= sin_t0 + fm;
			sdvs_pkg::OP_S3:  s2_q <= sin_t0 + fm;
			sdvs_pkg::OP_S4:  e2_q <= fm;
			sdvs_pkg::OP_S5:  body_q <= (s1_q >>> 1) + (fm >>> 1);
			sdvs_pkg::OP_S6,
			sdvs_pkg::OP_S7:  body_q <= fm;
			sdvs_pkg::OP_S12: begin
				out_data_q <= body_q + (fm <<< 2);
				out_last_q <= cmd.last;
				incw_q     <= incw_q + dinc_q;
				ebw_q      <= ebw_q + deb_q;
			end
			default: ;
		endcase
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/snare_drum_voice_synth.sv
// ----------------------------------------------------------------------------
// snare_drum_voice_synth
// Snare voice: sine body plus shaped noise, 32 samples per control beat.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | side
//  s_      | in  | pitch, fine, note, sweep, contour, color,     | tuser: kind
//          |     | shape, body decay, sweep decay               |
//  m_      | out | sample                                       | tlast: last
//
//  One control beat runs the setup steps, the accept step included, and then
//  the sample steps S1 to S12 for each sample of the block; the single shared
//  32x32 multiplier sets this step-by-step schedule.
//  Reset clears the voice state; the sine and brightness tables are constant.
//  A stalled m_ side holds the sequencer at the output step of each sample.
//  s_tready is high only while no block is being rendered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module snare_drum_voice_synth (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [183:0] s_tdata,  // pitch_word, fine_word, note_offset, sweep_word,
	                               // contour_word, color_word, shape_word,
	                               // body_decay_factor, sweep_decay_factor
	input  logic         s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // sample
	output logic         m_tlast
);

	sdvs_pkg::cmd_t    cmd;
	sdvs_pkg::status_t status;

	sdvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sdvs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.status    (status),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_valid (m_tvalid)
	);

	`ASSERT_IMPLY(a_emit_free, cmd.op == sdvs_pkg::OP_S12, !m_tvalid || m_tready)
	`ASSERT_IMPLY(a_idle_ops, s_tready, cmd.op == sdvs_pkg::OP_NOP || cmd.op == sdvs_pkg::OP_LOAD)
	`ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready)

endmodule
